>>> hw/rtl/mhs_pkg.sv
package mhs_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = PTR_BITS + 1;

    localparam logic [2:0] CODE_NONE     = 3'd0;
    localparam logic [2:0] CODE_PREV     = 3'd1;
    localparam logic [2:0] CODE_CUR      = 3'd2;
    localparam logic [2:0] CODE_PREV_CUR = 3'd3;
    localparam logic [2:0] CODE_NEXT     = 3'd4;
    localparam logic [2:0] CODE_OUTER    = 3'd5;
    localparam logic [2:0] CODE_CUR_NEXT = 3'd6;
    localparam logic [2:0] CODE_ALL      = 3'd7;

    localparam logic [WEIGHT_BITS-1:0] W_ONE     = WEIGHT_BITS'(65536);
    localparam logic [WEIGHT_BITS-1:0] W_HALF    = WEIGHT_BITS'(32768);
    localparam logic [WEIGHT_BITS-1:0] W_QUARTER = WEIGHT_BITS'(16384);
    localparam logic [WEIGHT_BITS-1:0] W_THIRD   = WEIGHT_BITS'(21845);
    localparam logic [WEIGHT_BITS-1:0] W_2THIRDS = WEIGHT_BITS'(43691);
    localparam logic [WEIGHT_BITS-1:0] W_ZERO    = '0;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w_prev;
        logic [WEIGHT_BITS-1:0] w_cur;
        logic [WEIGHT_BITS-1:0] w_next;
    } weights_t;

    typedef struct packed {
        logic       vld;
        logic [2:0] code;
        sample_t    prev;
        sample_t    cur;
        sample_t    next;
        logic       valid0;
        logic       last0;
        logic       has1;
        sample_t    value1;
        logic       valid1;
    } job_t;

    typedef struct packed {
        sample_t value;
        logic    valid;
        logic    last;
    } result_t;

    function automatic weights_t tap_weights(input logic [2:0] code);
        weights_t w;
        w = '{W_ZERO, W_ZERO, W_ZERO};
        case (code)
            CODE_PREV:     w = '{W_ONE, W_ZERO, W_ZERO};
            CODE_CUR:      w = '{W_ZERO, W_ONE, W_ZERO};
            CODE_PREV_CUR: w = '{W_THIRD, W_2THIRDS, W_ZERO};
            CODE_NEXT:     w = '{W_ZERO, W_ZERO, W_ONE};
            CODE_OUTER:    w = '{W_HALF, W_ZERO, W_HALF};
            CODE_CUR_NEXT: w = '{W_ZERO, W_2THIRDS, W_THIRD};
            CODE_ALL:      w = '{W_QUARTER, W_HALF, W_QUARTER};
            default:       w = '{W_ZERO, W_ZERO, W_ZERO};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/mhs_weigher.sv
module mhs_weigher (
    input  logic             aclk,
    input  logic             aresetn,
    input  mhs_pkg::job_t    job,
    output logic             busy,
    output logic             push0,
    output mhs_pkg::result_t res0,
    output logic             push1,
    output mhs_pkg::result_t res1
);

    localparam logic signed [mhs_pkg::SUM_BITS-1:0] ROUND_HALF =
        mhs_pkg::SUM_BITS'(1) <<< (mhs_pkg::FRAC_BITS - 1);

    mhs_pkg::weights_t w;
    logic signed [mhs_pkg::PROD_BITS-1:0] p_prev_reg, p_cur_reg, p_next_reg;
    logic          vld_reg;
    logic          valid0_reg, last0_reg, has1_reg, valid1_reg;
    mhs_pkg::sample_t value1_reg;
    logic signed [mhs_pkg::SUM_BITS-1:0] sum;
    logic signed [mhs_pkg::SUM_BITS-1:0] rounded;

    assign w = mhs_pkg::tap_weights(job.code);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= job.vld;
        end
    end

    always_ff @(posedge aclk) begin
        p_prev_reg <= job.prev * $signed({1'b0, w.w_prev});
        p_cur_reg  <= job.cur  * $signed({1'b0, w.w_cur});
        p_next_reg <= job.next * $signed({1'b0, w.w_next});
        valid0_reg <= job.valid0;
        last0_reg  <= job.last0;
        has1_reg   <= job.has1;
        value1_reg <= job.value1;
        valid1_reg <= job.valid1;
    end

    assign sum = mhs_pkg::SUM_BITS'(p_prev_reg) + mhs_pkg::SUM_BITS'(p_cur_reg)
               + mhs_pkg::SUM_BITS'(p_next_reg) + ROUND_HALF;
    assign rounded = sum >>> mhs_pkg::FRAC_BITS;

    assign busy  = vld_reg;
    assign push0 = vld_reg;
    assign push1 = vld_reg & has1_reg;
    assign res0  = '{rounded[mhs_pkg::SAMPLE_BITS-1:0], valid0_reg, last0_reg};
    assign res1  = '{value1_reg, valid1_reg, 1'b1};

endmodule

>>> hw/rtl/mhs_out_fifo.sv
module mhs_out_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push0,
    input  mhs_pkg::result_t                res0,
    input  logic                            push1,
    input  mhs_pkg::result_t                res1,
    input  logic                            pop,
    output mhs_pkg::result_t                head,
    output logic                            not_empty,
    output logic [mhs_pkg::CNT_BITS-1:0]    count
);

    mhs_pkg::result_t mem [mhs_pkg::FIFO_DEPTH];
    logic [mhs_pkg::PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [mhs_pkg::PTR_BITS-1:0] wr_ptr1;
    logic [mhs_pkg::CNT_BITS-1:0] count_reg, count_next;

    assign wr_ptr1     = wr_ptr_reg + mhs_pkg::PTR_BITS'(push0);
    assign wr_ptr_next = wr_ptr1 + mhs_pkg::PTR_BITS'(push1);
    assign rd_ptr_next = rd_ptr_reg + mhs_pkg::PTR_BITS'(pop);
    assign count_next  = count_reg + mhs_pkg::CNT_BITS'(push0) + mhs_pkg::CNT_BITS'(push1)
                       - mhs_pkg::CNT_BITS'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem[wr_ptr_reg] <= res0;
        end
        if (push1) begin
            mem[wr_ptr1] <= res1;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

>>> hw/rtl/masked_hanning_smoother.sv
// Results caused by an item pass through the job register, the weigher's product registers
// and the result queue before they show on m_*. The first sample of a spectrum is held
// until its successor arrives; the last flushes two, or one if it is also the first.
// Throughput: one input transfer per cycle, one output transfer per cycle; input stalls
// only when the 8-entry result queue could not absorb the items in flight.
// Reset (aresetn low, synchronous): clears sample history, selects strict mode, empties queue.
module masked_hanning_smoother (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // relaxed_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] sample_value
    input  logic        s_tuser,       // sample_valid
    input  logic        s_tlast,       // spectrum_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] smoothed_value
    output logic        m_tuser,       // smoothed_valid
    output logic        m_tlast        // result_last
);

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    logic             relaxed_reg;
    mhs_pkg::sample_t older_sample_reg, held_sample_reg;
    logic             older_valid_reg, held_valid_reg;
    logic [1:0]       items_held_reg;
    mhs_pkg::job_t    job_reg, job_next;

    mhs_pkg::sample_t v;
    logic             ok, last_in, accept, use_w;
    logic [2:0]       mask;

    logic             busy, push0, push1, pop, not_empty;
    mhs_pkg::result_t res0, res1, head;
    logic [mhs_pkg::CNT_BITS-1:0] count;
    logic [mhs_pkg::CNT_BITS:0]   reserved;

    assign v       = s_tdata;
    assign ok      = s_tuser;
    assign last_in = s_tlast;
    assign accept  = s_tvalid & s_tready;

    assign reserved = (mhs_pkg::CNT_BITS + 1)'(count)
                    + (mhs_pkg::CNT_BITS + 1)'({job_reg.vld, 1'b0})
                    + (mhs_pkg::CNT_BITS + 1)'({busy, 1'b0});
    assign s_tready = (reserved <= (mhs_pkg::CNT_BITS + 1)'(mhs_pkg::FIFO_DEPTH - 2));

    assign mask  = {ok, held_valid_reg, older_valid_reg};
    assign use_w = relaxed_reg ? (mask == mhs_pkg::CODE_ALL) : (mask != mhs_pkg::CODE_NONE);

    always_comb begin
        job_next.vld    = accept;
        job_next.code   = mhs_pkg::CODE_CUR;
        job_next.prev   = older_sample_reg;
        job_next.cur    = held_sample_reg;
        job_next.next   = v;
        job_next.valid0 = held_valid_reg;
        job_next.last0  = 1'b0;
        job_next.has1   = last_in;
        job_next.value1 = v;
        job_next.valid1 = ok;
        case (items_held_reg)
            HELD_NONE: begin
                job_next.vld    = accept & last_in;
                job_next.cur    = v;
                job_next.valid0 = ok;
                job_next.last0  = 1'b1;
                job_next.has1   = 1'b0;
            end
            HELD_TWO: begin
                job_next.code = use_w ? mask : mhs_pkg::CODE_CUR;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relaxed_reg      <= 1'b0;
            older_sample_reg <= '0;
            older_valid_reg  <= 1'b0;
            held_sample_reg  <= '0;
            held_valid_reg   <= 1'b0;
            items_held_reg   <= HELD_NONE;
            job_reg.vld      <= 1'b0;
        end else begin
            if (cfg_we) begin
                relaxed_reg <= cfg_wdata;
            end
            job_reg.vld <= job_next.vld;
            if (accept) begin
                if (items_held_reg == HELD_NONE) begin
                    if (!last_in) begin
                        held_sample_reg <= v;
                        held_valid_reg  <= ok;
                        items_held_reg  <= HELD_ONE;
                    end
                end else if (last_in) begin
                    older_sample_reg <= '0;
                    older_valid_reg  <= 1'b0;
                    held_sample_reg  <= '0;
                    held_valid_reg   <= 1'b0;
                    items_held_reg   <= HELD_NONE;
                end else begin
                    older_sample_reg <= held_sample_reg;
                    older_valid_reg  <= held_valid_reg;
                    held_sample_reg  <= v;
                    held_valid_reg   <= ok;
                    items_held_reg   <= HELD_TWO;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg.code   <= job_next.code;
        job_reg.prev   <= job_next.prev;
        job_reg.cur    <= job_next.cur;
        job_reg.next   <= job_next.next;
        job_reg.valid0 <= job_next.valid0;
        job_reg.last0  <= job_next.last0;
        job_reg.has1   <= job_next.has1;
        job_reg.value1 <= job_next.value1;
        job_reg.valid1 <= job_next.valid1;
    end

    mhs_weigher u_weigher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job     (job_reg),
        .busy    (busy),
        .push0   (push0),
        .res0    (res0),
        .push1   (push1),
        .res1    (res1)
    );

    assign pop = not_empty & m_tready;

    mhs_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (push0),
        .res0      (res0),
        .push1     (push1),
        .res1      (res1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (count)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = head.value;
    assign m_tuser  = head.valid;
    assign m_tlast  = head.last;

endmodule

>>> hw/rtl/mhs_checker.sv
module mhs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output transfer changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |-> ##3 m_tvalid)
        else $error("spectrum end did not produce output in time");

endmodule

bind masked_hanning_smoother mhs_checker u_mhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> verif/masked_hanning_smoother_test.sv
module masked_hanning_smoother_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mhs_pkg::sample_t value;
        bit               valid;
        bit               last;
    } smoothed_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] sample_value
    logic        s_tuser = 1'b0;   // sample_valid
    logic        s_tlast = 1'b0;   // spectrum_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] smoothed_value
    logic        m_tuser;          // smoothed_valid
    logic        m_tlast;          // result_last

    // smoother state as the block should hold it
    bit               relaxed_mode = 1'b0;
    mhs_pkg::sample_t prev_tap = '0;
    bit               prev_ok = 1'b0;
    mhs_pkg::sample_t cur_tap = '0;
    bit               cur_ok = 1'b0;
    int               taps_held = 0;

    smoothed_t smoothed_expected[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 32;
    int        recv_idle_pct = 52;
    int        ready_hold_request = 0;

    masked_hanning_smoother uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic mhs_pkg::sample_t hanning_tap(mhs_pkg::sample_t p, mhs_pkg::sample_t c,
                                                     mhs_pkg::sample_t n, logic [2:0] code);
        longint wp, wc, wn, acc;
        wp = 0;
        wc = 0;
        wn = 0;
        case (code)
            mhs_pkg::CODE_PREV: begin
                wp = mhs_pkg::W_ONE;
            end
            mhs_pkg::CODE_CUR: begin
                wc = mhs_pkg::W_ONE;
            end
            mhs_pkg::CODE_PREV_CUR: begin
                wp = mhs_pkg::W_THIRD;
                wc = mhs_pkg::W_2THIRDS;
            end
            mhs_pkg::CODE_NEXT: begin
                wn = mhs_pkg::W_ONE;
            end
            mhs_pkg::CODE_OUTER: begin
                wp = mhs_pkg::W_HALF;
                wn = mhs_pkg::W_HALF;
            end
            mhs_pkg::CODE_CUR_NEXT: begin
                wc = mhs_pkg::W_2THIRDS;
                wn = mhs_pkg::W_THIRD;
            end
            mhs_pkg::CODE_ALL: begin
                wp = mhs_pkg::W_QUARTER;
                wc = mhs_pkg::W_HALF;
                wn = mhs_pkg::W_QUARTER;
            end
            default: begin
            end
        endcase
        acc = p * wp + c * wc + n * wn;
        // nearest, ties toward +inf
        acc = (acc + 64'sd32768) >>> 16;
        return mhs_pkg::sample_t'(acc);
    endfunction

    function automatic void queue_result(mhs_pkg::sample_t value, bit ok, bit last_flag);
        smoothed_t r;
        r.value = value;
        r.valid = ok;
        r.last = last_flag;
        smoothed_expected = {smoothed_expected, r};
    endfunction

    function automatic void predict_smoothed(mhs_pkg::sample_t value, bit ok, bit last_flag);
        logic [2:0]       code;
        bit               weigh;
        mhs_pkg::sample_t mid;
        if (taps_held == 0 && last_flag) begin
            queue_result(value, ok, 1'b1);
        end else if (taps_held == 0) begin
            cur_tap = value;
            cur_ok = ok;
            taps_held = 1;
        end else begin
            if (taps_held == 1) begin
                mid = cur_tap;
            end else begin
                code = {ok, cur_ok, prev_ok};
                weigh = relaxed_mode ? (code == mhs_pkg::CODE_ALL)
                                     : (code != mhs_pkg::CODE_NONE);
                mid = weigh ? hanning_tap(prev_tap, cur_tap, value, code) : cur_tap;
            end
            queue_result(mid, cur_ok, 1'b0);
            prev_tap = cur_tap;
            prev_ok = cur_ok;
            cur_tap = value;
            cur_ok = ok;
            taps_held = 2;
            if (last_flag) begin
                queue_result(value, ok, 1'b1);
                prev_tap = '0;
                prev_ok = 1'b0;
                cur_tap = '0;
                cur_ok = 1'b0;
                taps_held = 0;
            end
        end
    endfunction

    function automatic mhs_pkg::sample_t pick_sample();
        mhs_pkg::sample_t pick;
        case ($urandom_range(7))
            0: pick = 32'h7FFF_FFFF;
            1: pick = 32'h8000_0000;
            2: pick = mhs_pkg::sample_t'(int'($urandom_range(131072)) - 65536);
            3: pick = mhs_pkg::sample_t'($urandom_range(3)) << 15;
            default: pick = $urandom;
        endcase
        return pick;
    endfunction

    task automatic send_sample(mhs_pkg::sample_t value, bit ok, bit last_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= ok;
        s_tlast <= last_flag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_smoothed(value, ok, last_flag);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (smoothed_expected.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_mode(bit relaxed);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= relaxed;
        @(posedge aclk);
        cfg_we <= 1'b0;
        relaxed_mode = relaxed;
    endtask

    task automatic run_spectra(int item_goal);
        int sent, span, valid_pct;
        sent = 0;
        while (sent < item_goal) begin
            span = ($urandom_range(15) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            case ($urandom_range(3))
                0: valid_pct = 20;
                1: valid_pct = 60;
                default: valid_pct = 95;
            endcase
            for (int k = 0; k < span; k++)
                send_sample(pick_sample(), $urandom_range(99) < valid_pct, k == span - 1);
            sent += span;
        end
    endtask

    // mask walk covering every prev/cur/next validity combination
    task automatic send_mask_pattern();
        mhs_pkg::sample_t vals[10] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h0001_8000, 32'hFFFF_FFFF, 32'h1234_5678,
                                       32'h0000_0000};
        bit      oks[10] = '{0, 0, 0, 1, 1, 1, 0, 1, 0, 0};
        for (int k = 0; k < 10; k++)
            send_sample(vals[k], oks[k], k == 9);
    endtask

    task automatic test_directed_strict();
        send_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h0000_0001, 1'b1, 1'b1);
        // rounding ties, positive and negative
        send_sample(1, 1'b1, 1'b0);
        send_sample(0, 1'b1, 1'b0);
        send_sample(1, 1'b1, 1'b1);
        send_sample(-1, 1'b1, 1'b0);
        send_sample(0, 1'b1, 1'b0);
        send_sample(-1, 1'b1, 1'b1);
        send_mask_pattern();
    endtask

    task automatic test_directed_relaxed();
        write_mode(1'b1);
        send_mask_pattern();
    endtask

    task automatic test_random(bit relaxed, int send_pct, int recv_pct, int item_goal);
        write_mode(relaxed);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_spectra(item_goal);
    endtask

    task automatic test_backpressure();
        write_mode(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ready_hold_request = 300;
        run_spectra(80);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (ready_hold_request != 0) begin
                hold_left = ready_hold_request;
                ready_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        smoothed_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (smoothed_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: value %h valid %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = smoothed_expected.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.valid
                        || m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("bad transfer: expected %h/%b/%b got %h/%b/%b",
                                 want.value, want.valid, want.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_strict();
        test_directed_relaxed();
        test_random(1'b1, 32, 52, 220);
        test_random(1'b0, 52, 32, 220);
        test_random(1'b1, 0, 0, 100);
        test_random(1'b0, 0, 0, 100);
        test_backpressure();
        drain_results();
        if (mismatch_count == 0 && smoothed_expected.size() == 0) begin
            $display("masked_hanning_smoother: match");
        end else begin
            $display("masked_hanning_smoother: mismatch");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("masked_hanning_smoother: mismatch");
        $finish;
    end

endmodule
